>>> rtl/sdspi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD SPI engine package
// Shared codes, constants and types of the SD card SPI-mode host engine.
// ----------------------------------------------------------------------------
package sdspi_pkg;

	// Default sector length in bytes
	localparam int SD_SECTOR_BYTES = 512;

	// Request kinds
	localparam logic [1:0] KIND_RX   = 2'd0;
	localparam logic [1:0] KIND_INIT = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] CFG_IDLE_RETRIES   = 3'd0;
	localparam logic [2:0] CFG_READY_RETRIES  = 3'd1;
	localparam logic [2:0] CFG_TOKEN_POLLS    = 3'd2;
	localparam logic [2:0] CFG_RESPONSE_POLLS = 3'd3;
	localparam logic [2:0] CFG_WAKE_BYTES     = 3'd4;
	localparam logic [2:0] CFG_SLOW_DIVIDER   = 3'd5;
	localparam logic [2:0] CFG_FAST_DIVIDER   = 3'd6;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 12;

	// Configuration reset values
	localparam logic [7:0]  RST_IDLE_RETRIES   = 8'd20;
	localparam logic [11:0] RST_READY_RETRIES  = 12'd1500;
	localparam logic [11:0] RST_TOKEN_POLLS    = 12'd1000;
	localparam logic [7:0]  RST_RESPONSE_POLLS = 8'd8;
	localparam logic [7:0]  RST_WAKE_BYTES     = 8'd20;
	localparam logic [7:0]  RST_SLOW_DIVIDER   = 8'd255;
	localparam logic [7:0]  RST_FAST_DIVIDER   = 8'd0;

	// SD commands
	localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
	localparam logic [5:0] CMD_IF_COND   = 6'd8;
	localparam logic [5:0] CMD_READ_ONE  = 6'd17;
	localparam logic [5:0] CMD_OP_COND   = 6'd41;
	localparam logic [5:0] CMD_APP       = 6'd55;
	localparam logic [5:0] CMD_READ_OCR  = 6'd58;

	localparam logic [7:0]  CMD_START     = 8'h40;
	localparam logic [7:0]  CRC_GO_IDLE   = 8'h95;
	localparam logic [7:0]  CRC_IF_COND   = 8'h87;
	localparam logic [31:0] ARG_IF_COND   = 32'h0000_01AA;
	localparam logic [11:0] ECHO_IF_COND  = 12'h1AA;
	localparam logic [31:0] ARG_HCS       = 32'h4000_0000;
	localparam int          OCR_CCS_BIT   = 30;
	localparam logic [7:0]  DATA_TOKEN    = 8'hFE;
	localparam logic [7:0]  IDLE_BYTE     = 8'hFF;
	localparam logic [7:0]  R1_IDLE       = 8'h01;
	localparam logic [7:0]  R1_READY      = 8'h00;
	localparam logic [2:0]  FRAME_LAST    = 3'd5;
	localparam logic [1:0]  R32_LAST      = 2'd3;

	// Completion status
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_IO_ERROR  = 3'd1,
		ST_TIMEOUT   = 3'd2,
		ST_NOT_HC    = 3'd3,
		ST_NOT_READY = 3'd4
	} status_t;

	// Engine phases
	typedef enum logic [7:0] {
		PH_IDLE  = 8'b0000_0001,
		PH_WAKE  = 8'b0000_0010,
		PH_CMD   = 8'b0000_0100,
		PH_RESP  = 8'b0000_1000,
		PH_R32   = 8'b0001_0000,
		PH_TOKEN = 8'b0010_0000,
		PH_DATA  = 8'b0100_0000,
		PH_CRC   = 8'b1000_0000
	} phase_t;

	// Result item as held in the output register
	typedef struct packed {
		logic       transfer;
		logic [7:0] tx_byte;
		logic       chip_select;
		logic [7:0] clock_divider;
		logic       data_valid;
		logic [7:0] data_byte;
		logic       done_res;
		logic [2:0] status;
	} result_t;

	// Byte k of a six-byte command frame
	function automatic logic [7:0] frame_byte(
		input logic [2:0]  k,
		input logic [5:0]  cmd,
		input logic [31:0] arg
	);
		logic [7:0] b;
		case (k)
			3'd0:    b = CMD_START | {2'b00, cmd};
			3'd1:    b = arg[31:24];
			3'd2:    b = arg[23:16];
			3'd3:    b = arg[15:8];
			3'd4:    b = arg[7:0];
			default: begin
				if (cmd == CMD_GO_IDLE) b = CRC_GO_IDLE;
				else if (cmd == CMD_IF_COND) b = CRC_IF_COND;
				else b = IDLE_BYTE;
			end
		endcase
		return b;
	endfunction

endpackage

>>> rtl/sdspi_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD SPI engine channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sdspi_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] sector_address;
	logic [7:0]  rx_byte;

	modport source (output valid, kind, sector_address, rx_byte, input ready);
	modport sink   (input valid, kind, sector_address, rx_byte, output ready);
endinterface

interface sdspi_res_if;
	logic       valid;
	logic       ready;
	logic       transfer;
	logic [7:0] tx_byte;
	logic       chip_select;
	logic [7:0] clock_divider;
	logic       data_valid;
	logic [7:0] data_byte;
	logic       done_res;
	logic [2:0] status;

	modport source (output valid, transfer, tx_byte, chip_select, clock_divider,
		data_valid, data_byte, done_res, status, input ready);
	modport sink   (input valid, transfer, tx_byte, chip_select, clock_divider,
		data_valid, data_byte, done_res, status, output ready);
endinterface

>>> rtl/sd_spi_card_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD card SPI-mode host engine
// Card init sequence and single-block read, one SPI byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item per SPI byte: a start-init request, a read request
//   with its block address, or the byte received for the transfer that the
//   previous result asked for. res returns exactly one result per item: the
//   next byte to send (if any), chip select, clock divider, an optional sector
//   data byte and a completion flag with status.
//   Every item is decoded combinationally against the engine state and its
//   result is captured in the output register, so it appears in the cycle
//   after the item is taken; one item is taken per cycle while res is free
//   or being drained. If res stalls, the output register holds its result and
//   req.ready drops until the result is taken.
//   Reset leaves the engine idle, the card unselected, the slow divider in use
//   and all configuration registers at their defaults. Configuration writes
//   go through cfg_write/cfg_index/cfg_data and take effect at the next edge;
//   issue them only while no item is in flight.
// ----------------------------------------------------------------------------
module sd_spi_card_engine
	import sdspi_pkg::*;
#(
	parameter int SECTOR_BYTES = SD_SECTOR_BYTES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	sdspi_req_if.sink              req,
	sdspi_res_if.source            res
);

	localparam int CountW = $clog2(SECTOR_BYTES + 1);

	// Configuration registers
	logic [7:0]  idle_retries_q, response_polls_q, wake_bytes_q;
	logic [7:0]  slow_divider_q, fast_divider_q;
	logic [11:0] ready_retries_q, token_polls_q;

	// Engine state
	phase_t            phase_q, phase_d;
	logic [CountW-1:0] byte_count_q, byte_count_d;
	logic [11:0]       retry_count_q, retry_count_d;
	logic [11:0]       poll_count_q, poll_count_d;
	logic [5:0]        command_q, command_d;
	logic [31:0]       argument_q, argument_d;
	logic [31:0]       response_q, response_d;
	logic              card_ready_q, card_ready_d;
	logic              select_q, select_d;
	logic [7:0]        divider_q, divider_d;

	// Output register
	result_t res_q, res_d;
	logic    res_valid_q;
	logic    accept;

	// Next-step helpers
	logic              start_cmd, start_r32, init_fail, finish;
	logic [5:0]        sc_cmd;
	logic [31:0]       sc_arg;
	status_t           fin_st;
	logic [CountW-1:0] bc_inc;
	logic [11:0]       retry_inc, poll_inc;
	logic [31:0]       r32_word;

	assign accept    = req.valid & req.ready;
	assign req.ready = ~res_valid_q | res.ready;

	assign bc_inc    = byte_count_q + CountW'(1);
	assign retry_inc = retry_count_q + 12'd1;
	assign poll_inc  = poll_count_q + 12'd1;
	assign r32_word  = {response_q[23:0], req.rx_byte};

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_retries_q   <= RST_IDLE_RETRIES;
			ready_retries_q  <= RST_READY_RETRIES;
			token_polls_q    <= RST_TOKEN_POLLS;
			response_polls_q <= RST_RESPONSE_POLLS;
			wake_bytes_q     <= RST_WAKE_BYTES;
			slow_divider_q   <= RST_SLOW_DIVIDER;
			fast_divider_q   <= RST_FAST_DIVIDER;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_IDLE_RETRIES:   idle_retries_q   <= cfg_data[7:0];
				CFG_READY_RETRIES:  ready_retries_q  <= cfg_data;
				CFG_TOKEN_POLLS:    token_polls_q    <= cfg_data;
				CFG_RESPONSE_POLLS: response_polls_q <= cfg_data[7:0];
				CFG_WAKE_BYTES:     wake_bytes_q     <= cfg_data[7:0];
				CFG_SLOW_DIVIDER:   slow_divider_q   <= cfg_data[7:0];
				CFG_FAST_DIVIDER:   fast_divider_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Decode one item against the engine state
	always_comb begin
		phase_d      = phase_q;
		byte_count_d = byte_count_q;
		retry_count_d = retry_count_q;
		poll_count_d = poll_count_q;
		command_d    = command_q;
		argument_d   = argument_q;
		response_d   = response_q;
		card_ready_d = card_ready_q;
		select_d     = select_q;
		divider_d    = divider_q;

		start_cmd = 1'b0;
		start_r32 = 1'b0;
		init_fail = 1'b0;
		finish    = 1'b0;
		sc_cmd    = CMD_GO_IDLE;
		sc_arg    = '0;
		fin_st    = ST_OK;

		res_d.transfer   = 1'b0;
		res_d.tx_byte    = IDLE_BYTE;
		res_d.data_valid = 1'b0;
		res_d.data_byte  = 8'h00;
		res_d.done_res   = 1'b0;
		res_d.status     = ST_OK;

		case (req.kind)
			KIND_INIT: begin
				divider_d    = slow_divider_q;
				select_d     = 1'b0;
				card_ready_d = 1'b0;
				byte_count_d = '0;
				phase_d      = PH_WAKE;
				res_d.transfer = 1'b1;
			end
			KIND_READ: begin
				if (!card_ready_q) begin
					finish = 1'b1;
					fin_st = ST_NOT_READY;
				end else begin
					start_cmd = 1'b1;
					sc_cmd    = CMD_READ_ONE;
					sc_arg    = req.sector_address;
				end
			end
			KIND_RX: begin
				unique case (phase_q)
					PH_WAKE: begin
						byte_count_d = bc_inc;
						if (bc_inc >= CountW'(wake_bytes_q)) begin
							select_d      = 1'b1;
							retry_count_d = '0;
							start_cmd     = 1'b1;
						end else begin
							res_d.transfer = 1'b1;
						end
					end
					PH_CMD: begin
						byte_count_d = bc_inc;
						if (bc_inc <= CountW'(FRAME_LAST)) begin
							res_d.transfer = 1'b1;
							res_d.tx_byte  = frame_byte(bc_inc[2:0], command_q, argument_q);
						end else begin
							phase_d        = PH_RESP;
							poll_count_d   = '0;
							res_d.transfer = 1'b1;
						end
					end
					PH_RESP: begin
						poll_count_d = poll_inc;
						if (!req.rx_byte[7] || poll_inc >= {4'd0, response_polls_q}) begin
							// Act on the R1 of the command in flight
							case (command_q)
								CMD_GO_IDLE: begin
									if (req.rx_byte == R1_IDLE) begin
										retry_count_d = '0;
										start_cmd     = 1'b1;
										sc_cmd        = CMD_IF_COND;
										sc_arg        = ARG_IF_COND;
									end else begin
										retry_count_d = retry_inc;
										if (retry_inc >= {4'd0, idle_retries_q}) begin
											init_fail = 1'b1;
											fin_st    = ST_IO_ERROR;
										end else begin
											start_cmd = 1'b1;
										end
									end
								end
								CMD_IF_COND: begin
									if (req.rx_byte != R1_IDLE) begin
										init_fail = 1'b1;
										fin_st    = ST_IO_ERROR;
									end else begin
										start_r32 = 1'b1;
									end
								end
								CMD_APP: begin
									if (req.rx_byte != R1_IDLE) begin
										init_fail = 1'b1;
										fin_st    = ST_IO_ERROR;
									end else begin
										start_cmd = 1'b1;
										sc_cmd    = CMD_OP_COND;
										sc_arg    = ARG_HCS;
									end
								end
								CMD_OP_COND: begin
									if (req.rx_byte == R1_READY) begin
										start_cmd = 1'b1;
										sc_cmd    = CMD_READ_OCR;
									end else if (req.rx_byte != R1_IDLE) begin
										init_fail = 1'b1;
										fin_st    = ST_IO_ERROR;
									end else begin
										retry_count_d = retry_inc;
										if (retry_inc >= ready_retries_q) begin
											init_fail = 1'b1;
											fin_st    = ST_TIMEOUT;
										end else begin
											start_cmd = 1'b1;
											sc_cmd    = CMD_APP;
										end
									end
								end
								CMD_READ_OCR: begin
									start_r32 = 1'b1;
								end
								CMD_READ_ONE: begin
									if (req.rx_byte != R1_READY) begin
										finish = 1'b1;
										fin_st = ST_IO_ERROR;
									end else begin
										phase_d        = PH_TOKEN;
										poll_count_d   = '0;
										res_d.transfer = 1'b1;
									end
								end
								default: begin
									finish = 1'b1;
									fin_st = ST_IO_ERROR;
								end
							endcase
						end else begin
							res_d.transfer = 1'b1;
						end
					end
					PH_R32: begin
						response_d   = r32_word;
						byte_count_d = bc_inc;
						if (bc_inc <= CountW'(R32_LAST)) begin
							res_d.transfer = 1'b1;
						end else if (command_q == CMD_IF_COND) begin
							if (r32_word[11:0] != ECHO_IF_COND) begin
								init_fail = 1'b1;
								fin_st    = ST_IO_ERROR;
							end else begin
								retry_count_d = '0;
								start_cmd     = 1'b1;
								sc_cmd        = CMD_APP;
							end
						end else if (!r32_word[OCR_CCS_BIT]) begin
							init_fail = 1'b1;
							fin_st    = ST_NOT_HC;
						end else begin
							divider_d    = fast_divider_q;
							card_ready_d = 1'b1;
							finish       = 1'b1;
						end
					end
					PH_TOKEN: begin
						poll_count_d = poll_inc;
						if (req.rx_byte == DATA_TOKEN) begin
							phase_d        = PH_DATA;
							byte_count_d   = '0;
							res_d.transfer = 1'b1;
						end else if (poll_inc >= token_polls_q) begin
							finish = 1'b1;
							fin_st = ST_IO_ERROR;
						end else begin
							res_d.transfer = 1'b1;
						end
					end
					PH_DATA: begin
						res_d.data_valid = 1'b1;
						res_d.data_byte  = req.rx_byte;
						res_d.transfer   = 1'b1;
						byte_count_d     = bc_inc;
						if (bc_inc >= CountW'(SECTOR_BYTES)) begin
							phase_d      = PH_CRC;
							byte_count_d = '0;
						end
					end
					PH_CRC: begin
						byte_count_d = bc_inc;
						if (bc_inc >= CountW'(2)) finish = 1'b1;
						else res_d.transfer = 1'b1;
					end
					default: ;
				endcase
			end
			default: ;
		endcase

		// Launch a command frame
		if (start_cmd) begin
			command_d      = sc_cmd;
			argument_d     = sc_arg;
			byte_count_d   = '0;
			phase_d        = PH_CMD;
			res_d.transfer = 1'b1;
			res_d.tx_byte  = CMD_START | {2'b00, sc_cmd};
		end
		// Collect a four-byte response trailer
		if (start_r32) begin
			phase_d        = PH_R32;
			byte_count_d   = '0;
			response_d     = '0;
			res_d.transfer = 1'b1;
		end
		// Drop the card on init failure
		if (init_fail) begin
			select_d     = 1'b0;
			divider_d    = slow_divider_q;
			card_ready_d = 1'b0;
		end
		if (finish || init_fail) begin
			phase_d        = PH_IDLE;
			res_d.done_res = 1'b1;
			res_d.status   = fin_st;
		end

		res_d.chip_select   = select_d;
		res_d.clock_divider = divider_d;
	end

	// Advance engine state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			byte_count_q  <= '0;
			retry_count_q <= '0;
			poll_count_q  <= '0;
			command_q     <= '0;
			argument_q    <= '0;
			response_q    <= '0;
			card_ready_q  <= 1'b0;
			select_q      <= 1'b0;
			divider_q     <= RST_SLOW_DIVIDER;
		end else if (accept) begin
			phase_q       <= phase_d;
			byte_count_q  <= byte_count_d;
			retry_count_q <= retry_count_d;
			poll_count_q  <= poll_count_d;
			command_q     <= command_d;
			argument_q    <= argument_d;
			response_q    <= response_d;
			card_ready_q  <= card_ready_d;
			select_q      <= select_d;
			divider_q     <= divider_d;
		end
	end

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) res_q <= res_d;
	end

	assign res.valid         = res_valid_q;
	assign res.transfer      = res_q.transfer;
	assign res.tx_byte       = res_q.tx_byte;
	assign res.chip_select   = res_q.chip_select;
	assign res.clock_divider = res_q.clock_divider;
	assign res.data_valid    = res_q.data_valid;
	assign res.data_byte     = res_q.data_byte;
	assign res.done_res      = res_q.done_res;
	assign res.status        = res_q.status;

endmodule
